/* hw/rtl/dlcp_pkg.sv */
// Shared types and constants for the display-list command processor.
// No dependencies.
package dlcp_pkg;

    localparam int CALL_DEPTH_DEF = 64;
    localparam logic [20:0] MAX_WORDS_RST = 21'h100000;

    localparam logic [7:0] OP_VADDR  = 8'h01;
    localparam logic [7:0] OP_IADDR  = 8'h02;
    localparam logic [7:0] OP_PRIM   = 8'h04;
    localparam logic [7:0] OP_JUMP   = 8'h08;
    localparam logic [7:0] OP_CALL   = 8'h0a;
    localparam logic [7:0] OP_RET    = 8'h0b;
    localparam logic [7:0] OP_END    = 8'h0c;
    localparam logic [7:0] OP_SIGNAL = 8'h0e;
    localparam logic [7:0] OP_FINISH = 8'h0f;
    localparam logic [7:0] OP_BASE   = 8'h10;
    localparam logic [7:0] OP_VTYPE  = 8'h12;
    localparam logic [7:0] OP_OFFSET = 8'h13;
    localparam logic [7:0] OP_LOADC  = 8'hc4;
    localparam logic [7:0] OP_BLIT   = 8'hea;

    typedef enum logic [3:0] {
        ACT_UPDATE   = 4'd0,
        ACT_DRAW     = 4'd1,
        ACT_REJECT   = 4'd2,
        ACT_SIGNAL   = 4'd3,
        ACT_FINISH   = 4'd4,
        ACT_PALETTE  = 4'd5,
        ACT_BLIT     = 4'd6,
        ACT_END      = 4'd7,
        ACT_OVERFLOW = 4'd8,
        ACT_UNDERFLW = 4'd9,
        ACT_LIMIT    = 4'd10,
        ACT_STARTED  = 4'd11,
        ACT_IGNORED  = 4'd12
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] fetch_address;
        logic [23:0] event_argument;
        logic [31:0] draw_vertex_address;
        logic [31:0] draw_index_address;
        logic [15:0] draw_count;
        logic [2:0]  draw_prim_type;
        logic [23:0] draw_vertex_type;
        logic        list_running;
    } result_t;

endpackage

/* hw/rtl/dlcp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlcp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/display_list_command_processor_top.sv */
// Display-list command processor: combinational decode, result registered in
// the output register; throughput one request per cycle while in_stall is low,
// with the registered return-stack RAM read hidden by a top-of-stack register.
// Reset (rst_n, async) clears pointers, stack level, word count and run flag;
// the return-stack RAM is not cleared and needs no clearing pass.
// Depends on dlcp_pkg and dlcp_ram.
module display_list_command_processor_top
    import dlcp_pkg::*;
#(
    parameter int CALL_DEPTH = CALL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] max_words,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [31:0] start_address,
    input  logic [31:0] word,
    input  logic [7:0]  vertex_stride,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action,
    output logic [31:0] fetch_address,
    output logic [23:0] event_argument,
    output logic [31:0] draw_vertex_address,
    output logic [31:0] draw_index_address,
    output logic [15:0] draw_count,
    output logic [2:0]  draw_prim_type,
    output logic [23:0] draw_vertex_type,
    output logic        list_running
);

    localparam int LW = $clog2(CALL_DEPTH + 1);
    localparam int AW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(CALL_DEPTH);

    // Architectural state held in flops; table entries 0x10, 0x12 and 0x13 are
    // the only table entries the decoder reads, and only their used bits
    // are kept.
    logic [20:0] max_words_reg;
    logic [31:0] fetch_reg, fetch_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] vptr_reg, vptr_next;
    logic [31:0] iptr_reg, iptr_next;
    logic [3:0]  base_reg, base_next;
    logic [23:0] vtype_reg, vtype_next;
    logic [LW-1:0] level_reg, level_next;
    logic [20:0] seen_reg, seen_next;
    logic        run_reg, run_next;

    // Top of stack: either held here or arriving from the RAM after a pop.
    logic [63:0] tos_reg, tos_next;
    logic        tos_ram_reg, tos_ram_next;
    logic [63:0] tos_cur;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    // Output register plus one skid entry.
    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic accept, take;
    logic [7:0]  op;
    logic [23:0] arg;
    logic [31:0] next_addr, rel_val, rel_addr;
    logic [31:0] prod_v;
    logic [1:0]  itype;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign take      = out_valid_reg && !out_stall;
    assign tos_cur   = tos_ram_reg ? ram_rdata : tos_reg;

    assign op        = word[31:24];
    assign arg       = word[23:0];
    assign next_addr = fetch_reg + 32'd4;
    assign itype     = vtype_reg[12:11];
    assign prod_v    = 32'(arg[15:0]) * 32'(vertex_stride);

    // Base/offset relative address; jump and call drop the low two bits.
    always_comb
    begin
        if (op == OP_JUMP || op == OP_CALL)
        begin
            rel_val = {8'd0, arg[23:2], 2'b00};
        end
        else
        begin
            rel_val = {8'd0, arg};
        end
        rel_addr = (offset_reg + ({4'd0, base_reg, 24'd0} | rel_val))
                   & 32'h0fffffff;
    end

    always_comb
    begin
        fetch_next   = fetch_reg;
        offset_next  = offset_reg;
        vptr_next    = vptr_reg;
        iptr_next    = iptr_reg;
        base_next    = base_reg;
        vtype_next   = vtype_reg;
        level_next   = level_reg;
        seen_next    = seen_reg;
        run_next     = run_reg;
        tos_next     = tos_cur;
        tos_ram_next = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = level_reg[AW-1:0];
        ram_wdata    = {next_addr, offset_reg};
        ram_raddr    = AW'(level_reg - LW'(2));
        res          = '0;
        res.action   = ACT_UPDATE;

        if (accept)
        begin
            if (!cmd)
            begin
                fetch_next = start_address;
                level_next = '0;
                seen_next  = '0;
                run_next   = 1'b1;
                res.action = ACT_STARTED;
            end
            else if (!run_reg)
            begin
                res.action = ACT_IGNORED;
            end
            else if (seen_reg >= max_words_reg)
            begin
                run_next   = 1'b0;
                res.action = ACT_LIMIT;
            end
            else
            begin
                res.event_argument = arg;
                seen_next  = seen_reg + 21'd1;
                fetch_next = next_addr;
                if (op == OP_BASE)
                begin
                    base_next = word[19:16];
                end
                if (op == OP_VTYPE)
                begin
                    vtype_next = word[23:0];
                end
                case (op)
                    OP_VADDR:  vptr_next = rel_addr;
                    OP_IADDR:  iptr_next = rel_addr;
                    OP_LOADC:  res.action = ACT_PALETTE;
                    OP_BLIT:   res.action = ACT_BLIT;
                    OP_SIGNAL: res.action = ACT_SIGNAL;
                    OP_FINISH: res.action = ACT_FINISH;
                    OP_OFFSET: offset_next = {arg, 8'd0};
                    OP_PRIM:
                    begin
                        res.draw_prim_type      = arg[18:16];
                        res.draw_count          = arg[15:0];
                        res.draw_vertex_type    = vtype_reg;
                        res.draw_vertex_address = vptr_reg;
                        res.draw_index_address  = iptr_reg;
                        if (vertex_stride != 8'd0 && arg[18:16] != 3'd7)
                        begin
                            res.action = ACT_DRAW;
                            case (itype)
                                2'd0: vptr_next = vptr_reg + prod_v;
                                2'd1: iptr_next = iptr_reg + 32'(arg[15:0]);
                                2'd2: iptr_next = iptr_reg + {15'd0, arg[15:0], 1'b0};
                                default: iptr_next = iptr_reg + {14'd0, arg[15:0], 2'b00};
                            endcase
                        end
                        else
                        begin
                            res.action = ACT_REJECT;
                        end
                    end
                    OP_JUMP:   fetch_next = rel_addr;
                    OP_CALL:
                    begin
                        if (level_reg >= DEPTH_L)
                        begin
                            res.action = ACT_OVERFLOW;
                            run_next   = 1'b0;
                            seen_next  = seen_reg;
                            fetch_next = fetch_reg;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            tos_next   = {next_addr, offset_reg};
                            level_next = level_reg + LW'(1);
                            fetch_next = rel_addr;
                        end
                    end
                    OP_RET:
                    begin
                        if (level_reg == '0)
                        begin
                            res.action = ACT_UNDERFLW;
                            run_next   = 1'b0;
                            seen_next  = seen_reg;
                            fetch_next = fetch_reg;
                        end
                        else
                        begin
                            // Pop: next top comes from RAM next cycle.
                            level_next   = level_reg - LW'(1);
                            fetch_next   = tos_cur[63:32];
                            offset_next  = tos_cur[31:0];
                            tos_ram_next = 1'b1;
                        end
                    end
                    OP_END:
                    begin
                        res.action = ACT_END;
                        run_next   = 1'b0;
                        fetch_next = fetch_reg;
                    end
                    default: ;
                endcase
            end
            res.fetch_address = fetch_next;
            res.list_running  = run_next;
        end
    end

    dlcp_ram #(
        .WIDTH(64),
        .DEPTH(CALL_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_words_reg  <= MAX_WORDS_RST;
            fetch_reg      <= '0;
            offset_reg     <= '0;
            vptr_reg       <= '0;
            iptr_reg       <= '0;
            base_reg       <= '0;
            vtype_reg      <= '0;
            level_reg      <= '0;
            seen_reg       <= '0;
            run_reg        <= 1'b0;
            tos_reg        <= '0;
            tos_ram_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_words_reg <= max_words;
            end
            fetch_reg   <= fetch_next;
            offset_reg  <= offset_next;
            vptr_reg    <= vptr_next;
            iptr_reg    <= iptr_next;
            base_reg    <= base_next;
            vtype_reg   <= vtype_next;
            level_reg   <= level_next;
            seen_reg    <= seen_next;
            run_reg     <= run_next;
            tos_reg     <= tos_next;
            tos_ram_reg <= tos_ram_next;

            // Hold results: skid drains first, new request never overtakes.
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign action              = out_reg.action;
    assign fetch_address       = out_reg.fetch_address;
    assign event_argument      = out_reg.event_argument;
    assign draw_vertex_address = out_reg.draw_vertex_address;
    assign draw_index_address  = out_reg.draw_index_address;
    assign draw_count          = out_reg.draw_count;
    assign draw_prim_type      = out_reg.draw_prim_type;
    assign draw_vertex_type    = out_reg.draw_vertex_type;
    assign list_running        = out_reg.list_running;

endmodule
